[rtl/direction_angle_averager_top_defines.svh]
// assertion macros for the direction angle averager
// used by the port checker
`ifndef DIRECTION_ANGLE_AVERAGER_TOP_DEFINES_SVH
`define DIRECTION_ANGLE_AVERAGER_TOP_DEFINES_SVH
// implication checked on every clock edge outside reset
`define DAA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("daa check failed");
// next-cycle implication
`define DAA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("daa check failed");
`endif

[rtl/daa_pkg.sv]
// types and constants for the direction angle averager
// no dependencies
`timescale 1ns / 1ps
package daa_pkg;
    // component and angle widths are fixed by the beat layouts
    localparam int ComponentWidth = 16;
    localparam int AngleWidth     = 16;
    localparam logic [31:0] GainQ30 = 32'd652032874;

    typedef struct packed {
        logic signed [ComponentWidth-1:0] first_x;
        logic signed [ComponentWidth-1:0] first_y;
        logic signed [ComponentWidth-1:0] second_x;
        logic signed [ComponentWidth-1:0] second_y;
    } in_beat_t;

    typedef struct packed {
        logic signed [15:0]        dir_x;
        logic signed [15:0]        dir_y;
        logic [AngleWidth-1:0]     avg_angle;
        logic                      zero_vector;
    } out_beat_t;

    // atan(2^-i), 2^32 per full turn
    function automatic logic [31:0] turn_angle(input int i);
        logic [31:0] t;
        begin
            case (i)
                0: t = 32'h20000000;  1: t = 32'h12E4051E;
                2: t = 32'h09FB385B;  3: t = 32'h051111D4;
                4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
                6: t = 32'h00A2F61E;  7: t = 32'h00517C55;
                8: t = 32'h0028BE53;  9: t = 32'h00145F2F;
                10: t = 32'h000A2F98; 11: t = 32'h000517CC;
                12: t = 32'h00028BE6; 13: t = 32'h000145F3;
                14: t = 32'h0000A2FA; 15: t = 32'h0000517D;
                16: t = 32'h000028BE; 17: t = 32'h0000145F;
                18: t = 32'h00000A30; 19: t = 32'h00000518;
                20: t = 32'h0000028C; 21: t = 32'h00000146;
                22: t = 32'h000000A3; 23: t = 32'h00000051;
                default: t = 32'h0;
            endcase
            return t;
        end
    endfunction
endpackage

[rtl/direction_angle_averager_top.sv]
// top level of the direction angle averager
// depends on daa_pkg, daa_vec_stage and daa_rot_stage
`timescale 1ns / 1ps
// usage
// - in: valid/ready channel, one beat carries two vectors (daa_pkg::in_beat_t)
// - out: valid/ready channel, one beat per input beat (daa_pkg::out_beat_t)
// - pipeline: input register, CORDIC_STEPS vectoring stages (both vectors in
//   parallel), an average stage, CORDIC_STEPS rotation stages and an output
//   register
// - throughput: one beat per cycle while out is not held, each stage does one shift-add step
// - stall: when out is held the whole pipeline freezes; ready is high while
//   the output register is empty or being taken, so nothing is lost
// - reset: all valid bits clear, no beat in flight
// - a zero-length vector gives zero_vector = 1 and zero for the other fields
// - angles average plainly with no wraparound correction
module direction_angle_averager_top #(
    parameter int CORDIC_STEPS    = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  daa_pkg::in_beat_t    in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output daa_pkg::out_beat_t   out_data
);
    // components scaled by 2^16, plus growth and sign
    localparam int XW = daa_pkg::ComponentWidth + 16 + 3;
    localparam int AW = daa_pkg::AngleWidth;
    localparam int NV = CORDIC_STEPS;
    localparam logic [31:0] Half = 32'h80000000;

    // global enable: whole pipe advances unless the output is blocked
    logic en;
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // stage arrays, index 0 is input of first step
    logic                 v_vld  [NV+1];
    logic signed [XW-1:0] v_x1 [NV+1], v_y1 [NV+1], v_x2 [NV+1], v_y2 [NV+1];
    logic [31:0]          v_z1 [NV+1], v_z2 [NV+1];
    logic                 v_zero [NV+1];

    // input register: sign extend, scale, pre-rotate left half plane
    logic                 in_vld_reg;
    logic signed [XW-1:0] ix1_reg, iy1_reg, ix2_reg, iy2_reg;
    logic [31:0]          iz1_reg, iz2_reg;
    logic                 izero_reg;
    logic signed [XW-1:0] sx1, sy1, sx2, sy2;

    always_comb
    begin
        sx1 = XW'(in_data.first_x)  <<< 16;
        sy1 = XW'(in_data.first_y)  <<< 16;
        sx2 = XW'(in_data.second_x) <<< 16;
        sy2 = XW'(in_data.second_y) <<< 16;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (en)
            in_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ix1_reg <= sx1[XW-1] ? -sx1 : sx1;
            iy1_reg <= sx1[XW-1] ? -sy1 : sy1;
            iz1_reg <= sx1[XW-1] ? Half : 32'd0;
            ix2_reg <= sx2[XW-1] ? -sx2 : sx2;
            iy2_reg <= sx2[XW-1] ? -sy2 : sy2;
            iz2_reg <= sx2[XW-1] ? Half : 32'd0;
            izero_reg <= (in_data.first_x == '0 && in_data.first_y == '0) ||
                         (in_data.second_x == '0 && in_data.second_y == '0);
        end
    end

    assign v_vld[0] = in_vld_reg;
    assign v_x1[0] = ix1_reg; assign v_y1[0] = iy1_reg; assign v_z1[0] = iz1_reg;
    assign v_x2[0] = ix2_reg; assign v_y2[0] = iy2_reg; assign v_z2[0] = iz2_reg;
    assign v_zero[0] = izero_reg;

    for (genvar g = 0; g < NV; g++)
    begin : g_vec
        daa_vec_stage #(.STEP(g), .XW(XW)) u_vec (
            .clk(clk), .rst_n(rst_n), .en(en), .valid_in(v_vld[g]),
            .x1_in(v_x1[g]), .y1_in(v_y1[g]), .z1_in(v_z1[g]),
            .x2_in(v_x2[g]), .y2_in(v_y2[g]), .z2_in(v_z2[g]),
            .zero_in(v_zero[g]), .valid_out(v_vld[g+1]),
            .x1_out(v_x1[g+1]), .y1_out(v_y1[g+1]), .z1_out(v_z1[g+1]),
            .x2_out(v_x2[g+1]), .y2_out(v_y2[g+1]), .z2_out(v_z2[g+1]),
            .zero_out(v_zero[g+1])
        );
    end

    // average stage: round each angle, add, halve, fold into half turn
    logic [31:0]          r1, r2;
    logic [AW-1:0]        a1, a2, avg;
    logic [AW:0]          sum;
    logic [31:0]          zw;

    always_comb
    begin
        r1  = v_z1[NV] + (32'd1 << (31 - AW));
        r2  = v_z2[NV] + (32'd1 << (31 - AW));
        a1  = r1[31 -: AW];
        a2  = r2[31 -: AW];
        sum = {1'b0, a1} + {1'b0, a2};
        avg = sum[AW:1];
        zw  = {avg, {(32 - AW){1'b0}}};
    end

    logic                   r_vld  [NV+1];
    logic signed [33:0]     r_x [NV+1], r_y [NV+1];
    logic [31:0]            r_z [NV+1];
    logic                   r_neg [NV+1], r_zero [NV+1];
    logic [AW-1:0]          r_ang [NV+1];

    logic                   av_vld_reg, av_neg_reg, av_zero_reg;
    logic [31:0]            av_z_reg;
    logic [AW-1:0]          av_ang_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            av_vld_reg <= 1'b0;
        else if (en)
            av_vld_reg <= v_vld[NV];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // second and third quarter: reduce by half a turn, negate later
            av_neg_reg  <= zw[31] ^ zw[30];
            av_z_reg    <= (zw[31] ^ zw[30]) ? zw - Half : zw;
            av_zero_reg <= v_zero[NV];
            av_ang_reg  <= avg;
        end
    end

    function automatic logic signed [33:0] GainQ30_s();
        return signed'({2'b00, daa_pkg::GainQ30});
    endfunction

    assign r_vld[0] = av_vld_reg;
    assign r_x[0]   = 34'(GainQ30_s());
    assign r_y[0]   = '0;
    assign r_z[0]   = av_z_reg;
    assign r_neg[0] = av_neg_reg;
    assign r_zero[0] = av_zero_reg;
    assign r_ang[0] = av_ang_reg;

    for (genvar g = 0; g < NV; g++)
    begin : g_rot
        daa_rot_stage #(.STEP(g), .AW(AW)) u_rot (
            .clk(clk), .rst_n(rst_n), .en(en), .valid_in(r_vld[g]),
            .x_in(r_x[g]), .y_in(r_y[g]), .z_in(r_z[g]), .neg_in(r_neg[g]),
            .zero_in(r_zero[g]), .ang_in(r_ang[g]),
            .valid_out(r_vld[g+1]), .x_out(r_x[g+1]), .y_out(r_y[g+1]),
            .z_out(r_z[g+1]), .neg_out(r_neg[g+1]), .zero_out(r_zero[g+1]),
            .ang_out(r_ang[g+1])
        );
    end

    // output stage: round to q14, negate, saturate
    function automatic logic signed [15:0] to_q14(input logic signed [33:0] v,
                                                  input logic neg);
        logic signed [34:0] t;
        logic signed [18:0] r;
        begin
            t = 35'(v) + 35'sd32768;
            r = t[34:16];
            if (neg)
                r = -r;
            if (r > 19'sd16384)
                r = 19'sd16384;
            if (r < -19'sd16384)
                r = -19'sd16384;
            return r[15:0];
        end
    endfunction

    logic               out_vld_reg;
    daa_pkg::out_beat_t out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= r_vld[NV];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (r_zero[NV])
            begin
                out_reg.dir_x       <= '0;
                out_reg.dir_y       <= '0;
                out_reg.avg_angle   <= '0;
                out_reg.zero_vector <= 1'b1;
            end
            else
            begin
                out_reg.dir_x       <= to_q14(r_x[NV], r_neg[NV]);
                out_reg.dir_y       <= to_q14(r_y[NV], r_neg[NV]);
                out_reg.avg_angle   <= r_ang[NV];
                out_reg.zero_vector <= 1'b0;
            end
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;
endmodule

[rtl/daa_vec_stage.sv]
// one pipelined vectoring cordic step for two vectors side by side
// depends on daa_pkg
`timescale 1ns / 1ps
module daa_vec_stage #(
    parameter int STEP = 0,
    parameter int XW   = 34
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 valid_in,
    input  logic signed [XW-1:0] x1_in,
    input  logic signed [XW-1:0] y1_in,
    input  logic [31:0]          z1_in,
    input  logic signed [XW-1:0] x2_in,
    input  logic signed [XW-1:0] y2_in,
    input  logic [31:0]          z2_in,
    input  logic                 zero_in,
    output logic                 valid_out,
    output logic signed [XW-1:0] x1_out,
    output logic signed [XW-1:0] y1_out,
    output logic [31:0]          z1_out,
    output logic signed [XW-1:0] x2_out,
    output logic signed [XW-1:0] y2_out,
    output logic [31:0]          z2_out,
    output logic                 zero_out
);
    localparam logic [31:0] Ang = daa_pkg::turn_angle(STEP);

    logic                 valid_reg;
    logic signed [XW-1:0] x1_reg, y1_reg, x2_reg, y2_reg;
    logic signed [XW-1:0] x1_next, y1_next, x2_next, y2_next;
    logic [31:0]          z1_reg, z2_reg, z1_next, z2_next;
    logic                 zero_reg;

    always_comb
    begin
        if (!y1_in[XW-1])
        begin
            x1_next = x1_in + (y1_in >>> STEP);
            y1_next = y1_in - (x1_in >>> STEP);
            z1_next = z1_in + Ang;
        end
        else
        begin
            x1_next = x1_in - (y1_in >>> STEP);
            y1_next = y1_in + (x1_in >>> STEP);
            z1_next = z1_in - Ang;
        end
        if (!y2_in[XW-1])
        begin
            x2_next = x2_in + (y2_in >>> STEP);
            y2_next = y2_in - (x2_in >>> STEP);
            z2_next = z2_in + Ang;
        end
        else
        begin
            x2_next = x2_in - (y2_in >>> STEP);
            y2_next = y2_in + (x2_in >>> STEP);
            z2_next = z2_in - Ang;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg <= x1_next; y1_reg <= y1_next; z1_reg <= z1_next;
            x2_reg <= x2_next; y2_reg <= y2_next; z2_reg <= z2_next;
            zero_reg <= zero_in;
        end
    end

    assign valid_out = valid_reg;
    assign x1_out = x1_reg; assign y1_out = y1_reg; assign z1_out = z1_reg;
    assign x2_out = x2_reg; assign y2_out = y2_reg; assign z2_out = z2_reg;
    assign zero_out = zero_reg;
endmodule

[rtl/daa_rot_stage.sv]
// one pipelined rotation cordic step
// depends on daa_pkg
`timescale 1ns / 1ps
module daa_rot_stage #(
    parameter int STEP = 0,
    parameter int AW   = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                valid_in,
    input  logic signed [33:0]  x_in,
    input  logic signed [33:0]  y_in,
    input  logic [31:0]         z_in,
    input  logic                neg_in,
    input  logic                zero_in,
    input  logic [AW-1:0]       ang_in,
    output logic                valid_out,
    output logic signed [33:0]  x_out,
    output logic signed [33:0]  y_out,
    output logic [31:0]         z_out,
    output logic                neg_out,
    output logic                zero_out,
    output logic [AW-1:0]       ang_out
);
    localparam logic [31:0] Ang = daa_pkg::turn_angle(STEP);

    logic               valid_reg, neg_reg, zero_reg;
    logic signed [33:0] x_reg, y_reg, x_next, y_next;
    logic [31:0]        z_reg, z_next;
    logic [AW-1:0]      ang_reg;

    always_comb
    begin
        if (!z_in[31])
        begin
            x_next = x_in - (y_in >>> STEP);
            y_next = y_in + (x_in >>> STEP);
            z_next = z_in - Ang;
        end
        else
        begin
            x_next = x_in + (y_in >>> STEP);
            y_next = y_in - (x_in >>> STEP);
            z_next = z_in + Ang;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next; y_reg <= y_next; z_reg <= z_next;
            neg_reg <= neg_in; zero_reg <= zero_in; ang_reg <= ang_in;
        end
    end

    assign valid_out = valid_reg;
    assign x_out = x_reg; assign y_out = y_reg; assign z_out = z_reg;
    assign neg_out = neg_reg; assign zero_out = zero_reg; assign ang_out = ang_reg;
endmodule

[rtl/daa_checker.sv]
// port-level checks for the direction angle averager
// depends on daa_pkg and direction_angle_averager_top_defines.svh
`timescale 1ns / 1ps
`include "direction_angle_averager_top_defines.svh"
module daa_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input daa_pkg::out_beat_t out_data
);
    // a stalled result holds
    `DAA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
    // ready follows the output side
    `DAA_ASSERT_IMP(a_ready, !out_valid || out_ready, in_ready)
    // zero flag clears the other fields
    `DAA_ASSERT_IMP(a_zero, out_valid && out_data.zero_vector,
        out_data.dir_x == 16'sd0 && out_data.dir_y == 16'sd0 && out_data.avg_angle == 16'd0)
    // x direction within unit range
    `DAA_ASSERT_IMP(a_range, out_valid,
        out_data.dir_x <= 16'sd16384 && out_data.dir_x >= -16'sd16384)
endmodule

bind direction_angle_averager_top daa_checker u_daa_checker (
    .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

[verif/direction_angle_averager_top_tb.sv]
// testbench for the direction angle averager: directed and random vector pairs,
// predicted direction and angle checked beat by beat; depends on daa_pkg and the top level
`timescale 1ns / 1ps
module direction_angle_averager_top_tb;
    localparam int AngW      = daa_pkg::AngleWidth;
    localparam int Steps     = 16;
    localparam int Latency   = 2 * Steps + 3;
    localparam int CycleCap  = 400000;

    // idling phases
    typedef enum int {PH_FLOW, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH} phase_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    daa_pkg::in_beat_t  in_data;
    logic               out_valid;
    logic               out_ready;
    daa_pkg::out_beat_t out_data;

    daa_pkg::in_beat_t  pending_beats[$];
    daa_pkg::out_beat_t expected_dirs[$];
    int        send_idle_pct;
    int        recv_stall_pct;
    int        hold_off_cycles;
    bit        pause_sender;
    int        errors;
    int        checked;
    int        cycle_count;
    int        zero_seen;

    direction_angle_averager_top #(
        .CORDIC_STEPS(Steps)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // floor shift of a signed 64-bit value
    function automatic longint asr(longint v, int s);
        return v >>> s;
    endfunction

    // table of atan(2^-i) in 2^32 per turn, zero past the end
    function automatic logic [31:0] atan_step(int i);
        logic [31:0] tbl [0:23];
        tbl = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
                32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
                32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
                32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
                32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
                32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
        return (i >= 0 && i < 24) ? tbl[i] : 32'h0;
    endfunction

    // vectoring pass: heading of (x, y) in AngW bits
    function automatic logic [AngW-1:0] heading(longint x0, longint y0);
        longint x;
        longint y;
        longint xs;
        longint ys;
        logic [31:0] z;
        x = x0 * 65536;
        y = y0 * 65536;
        z = '0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = 32'h80000000;
        end
        for (int i = 0; i < Steps; i++)
        begin
            xs = asr(x, i);
            ys = asr(y, i);
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + atan_step(i);
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - atan_step(i);
            end
        end
        z = z + (32'd1 << (31 - AngW));
        return z[31 -: AngW];
    endfunction

    // round to Q1.14, optional negate, saturate
    function automatic logic [15:0] q14(longint v, bit neg);
        longint r;
        r = asr(v + (64'sd1 <<< 15), 16);
        if (neg)
            r = -r;
        if (r > 16384)
            r = 16384;
        if (r < -16384)
            r = -16384;
        return r[15:0];
    endfunction

    function automatic daa_pkg::out_beat_t average_direction(daa_pkg::in_beat_t b);
        daa_pkg::out_beat_t r;
        logic [AngW:0] sum;
        logic [AngW-1:0] avg;
        logic [31:0] z;
        bit         neg;
        longint     x;
        longint     y;
        longint     xs;
        longint     ys;
        r = '0;
        if ((b.first_x == 0 && b.first_y == 0) || (b.second_x == 0 && b.second_y == 0))
        begin
            r.zero_vector = 1'b1;
            return r;
        end
        sum = heading(b.first_x, b.first_y) + heading(b.second_x, b.second_y);
        avg = sum[AngW:1];
        z = {avg, {(32 - AngW){1'b0}}};
        neg = (z[31:30] == 2'd1 || z[31:30] == 2'd2);
        if (neg)
            z = z - 32'h80000000;
        x = daa_pkg::GainQ30;
        y = 0;
        for (int i = 0; i < Steps; i++)
        begin
            xs = asr(x, i);
            ys = asr(y, i);
            if (!z[31])
            begin
                x = x - ys;
                y = y + xs;
                z = z - atan_step(i);
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + atan_step(i);
            end
        end
        r.dir_x = q14(x, neg);
        r.dir_y = q14(y, neg);
        r.avg_angle = avg;
        return r;
    endfunction

    // driver: offer the next pending beat, honouring idling and the pause
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            // current beat (if any) taken this edge
            if (pending_beats.size() > 0 && !pause_sender &&
                $urandom_range(99) >= send_idle_pct)
            begin
                in_data  <= pending_beats[0];
                in_valid <= 1'b1;
                expected_dirs.push_back(average_direction(pending_beats[0]));
                void'(pending_beats.pop_front());
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver ready, with a long hold-off counted here
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_off_cycles > 0)
        begin
            out_ready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor: compare every taken result with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_dirs.size() == 0)
            begin
                $display("%0t: unexpected beat, actual %h", $time, out_data);
                errors++;
            end
            else
            begin
                if (out_data.dir_x !== expected_dirs[0].dir_x ||
                    out_data.dir_y !== expected_dirs[0].dir_y ||
                    out_data.avg_angle !== expected_dirs[0].avg_angle ||
                    out_data.zero_vector !== expected_dirs[0].zero_vector)
                begin
                    $display("%0t: mismatch, expected x=%0d y=%0d ang=%0d z=%0b",
                             $time, expected_dirs[0].dir_x, expected_dirs[0].dir_y,
                             expected_dirs[0].avg_angle, expected_dirs[0].zero_vector);
                    $display("%0t:           actual x=%0d y=%0d ang=%0d z=%0b",
                             $time, out_data.dir_x, out_data.dir_y,
                             out_data.avg_angle, out_data.zero_vector);
                    errors++;
                end
                if (expected_dirs[0].zero_vector)
                    zero_seen++;
                void'(expected_dirs.pop_front());
                checked++;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleCap)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic signed [15:0] any_component();
        case ($urandom_range(5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'($signed($urandom_range(16)) - 8);
            3: return 16'd0;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic daa_pkg::in_beat_t any_pair();
        daa_pkg::in_beat_t b;
        b.first_x  = any_component();
        b.first_y  = any_component();
        b.second_x = any_component();
        b.second_y = any_component();
        // mostly non-zero vectors so the cordic path is exercised
        if ($urandom_range(19) != 0 && b.first_x == 0 && b.first_y == 0)
            b.first_y = 16'sd1;
        if ($urandom_range(19) != 0 && b.second_x == 0 && b.second_y == 0)
            b.second_x = -16'sd1;
        return b;
    endfunction

    task automatic add_pair(int ax, int ay, int bx, int by);
        daa_pkg::in_beat_t b;
        b.first_x  = 16'(ax);
        b.first_y  = 16'(ay);
        b.second_x = 16'(bx);
        b.second_y = 16'(by);
        pending_beats.push_back(b);
    endtask

    task automatic drain();
        while (pending_beats.size() > 0 || in_valid || expected_dirs.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        phase_t ph;
        errors          = 0;
        checked         = 0;
        zero_seen       = 0;
        cycle_count     = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_off_cycles = 0;
        pause_sender    = 1'b0;
        rst_n           = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: axes, extremes, zero vectors, opposite angles near the wrap
        add_pair(1, 0, 0, 1);
        add_pair(-1, 0, 0, -1);
        add_pair(32767, 32767, -32768, -32768);
        add_pair(-32768, 0, 32767, 0);
        add_pair(0, 32767, 0, -32768);
        add_pair(0, 0, 5, 5);
        add_pair(5, 5, 0, 0);
        add_pair(0, 0, 0, 0);
        add_pair(100, 1, 100, -1);
        add_pair(100, -1, 100, -1);
        add_pair(-100, 1, -100, -1);
        add_pair(-32768, -32768, -32768, -32768);
        add_pair(32767, -32768, -32768, 32767);
        add_pair(-1, -1, 1, 1);
        add_pair(1, -32768, -1, 32767);
        add_pair(-21846, 21845, 1234, -4321);
        drain();

        // long receiver hold-off while the sender keeps offering
        for (int i = 0; i < 120; i++)
            pending_beats.push_back(any_pair());
        hold_off_cycles = 200;
        drain();

        for (int p = 0; p < 8; p++)
        begin
            ph = phase_t'(p % 4);
            send_idle_pct  = (ph == PH_SEND_IDLE) ? 61 : (ph == PH_BOTH) ? 34 : 0;
            recv_stall_pct = (ph == PH_RECV_STALL) ? 61 : (ph == PH_BOTH) ? 34 : 0;
            for (int i = 0; i < 225; i++)
                pending_beats.push_back(any_pair());
            // in one pass the sender holds still until every result is back
            if (p == 5)
            begin
                while (pending_beats.size() > 100)
                    @(posedge clk);
                pause_sender = 1'b1;
                while (in_valid || expected_dirs.size() > 0)
                    @(posedge clk);
                pause_sender = 1'b0;
            end
            drain();
        end

        repeat (Latency + 10) @(posedge clk);
        $display("covered %0d beats, %0d with a zero-length vector, over four idling",
                 checked, zero_seen);
        $display("patterns plus a long output hold-off and a sender pause");
        if (errors == 0 && expected_dirs.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
